// ===== sv/tgff_pkg.sv =====
// shared types and constants for the tile grid flood fill block
// no dependencies; imported by tgff_ram users and the top level
package tgff_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 32;

    localparam int FUNC_W  = 2;
    localparam int COORD_W = 5;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_FILL  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_NBR,
        ST_RESULT
    } state_t;

    // neighbor order: west, east, north, south, then a drain step
    typedef enum logic [2:0] {
        DIR_W   = 3'd0,
        DIR_E   = 3'd1,
        DIR_N   = 3'd2,
        DIR_S   = 3'd3,
        DIR_END = 3'd4
    } dir_t;

endpackage

// ===== sv/tgff_ram.sv =====
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module tgff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tile_grid_flood_fill.sv =====
// tile grid with host cell access and 4-connected breadth-first flood fill
// depends on tgff_pkg and tgff_ram (cell map and cell queue)
//
// Each grid cell holds a tile byte and an attribute byte in one ram addressed
// by {row, column}. A fill reads the seed, then pops cells from a queue ram
// and probes the four neighbors through a single map read port, one neighbor
// per cycle, with the compare and repaint of one neighbor overlapping the
// read of the next. A cell is repainted as it enters the queue, so a
// repainted cell no longer matches the seed and needs no separate visited
// mark. Each popped cell passes through the pop and pop wait steps and then
// a sweep of the four neighbors and a drain step. The block takes no new item
// until the current one is done; a finished result waits in an output
// register while the next item is accepted.
module tile_grid_flood_fill #(
    parameter int GRID_WIDTH  = tgff_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tgff_pkg::GRID_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tgff_pkg::FUNC_W-1:0]   func,
    input  logic [tgff_pkg::COORD_W-1:0]  cell_x,
    input  logic [tgff_pkg::COORD_W-1:0]  cell_y,
    input  logic [tgff_pkg::BYTE_W-1:0]   tile_value,
    input  logic [tgff_pkg::BYTE_W-1:0]   attr_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tgff_pkg::BYTE_W-1:0]   read_tile,
    output logic [tgff_pkg::BYTE_W-1:0]   read_attr,
    output logic [tgff_pkg::CNT_W-1:0]    filled_count,
    output logic                          skipped
);

    import tgff_pkg::*;

    localparam int XW         = $clog2(GRID_WIDTH);
    localparam int YW         = $clog2(GRID_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int MAP_DEPTH  = 2 ** AW;
    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int QIW        = $clog2(CELL_COUNT);
    localparam int QW         = $clog2(CELL_COUNT + 1);
    localparam int CELL_W     = 2 * BYTE_W;

    state_t                state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [AW-1:0]         seed_addr_reg, seed_addr_next;
    logic [BYTE_W-1:0]     new_tile_reg, new_tile_next;
    logic [BYTE_W-1:0]     new_attr_reg, new_attr_next;
    logic [BYTE_W-1:0]     seed_tile_reg, seed_tile_next;
    logic [BYTE_W-1:0]     seed_attr_reg, seed_attr_next;
    logic                  skip_reg, skip_next;
    logic [QW-1:0]         head_reg, head_next;
    logic [QW-1:0]         tail_reg, tail_next;
    logic [AW-1:0]         cur_reg, cur_next;
    dir_t                  dir_reg, dir_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_tile_reg, out_tile_next;
    logic [BYTE_W-1:0]     out_attr_reg, out_attr_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_skip_reg, out_skip_next;

    logic                  map_we, map_re;
    logic [AW-1:0]         map_waddr, map_raddr;
    logic [CELL_W-1:0]     map_wdata, map_rdata;
    logic                  q_we, q_re;
    logic [QIW-1:0]        q_waddr, q_raddr;
    logic [AW-1:0]         q_wdata, q_rdata;

    logic                  accept;
    logic                  in_grid;
    logic [AW-1:0]         in_addr;
    logic [XW-1:0]         cur_x;
    logic [YW-1:0]         cur_y;
    logic                  nbr_ok;
    logic [AW-1:0]         nbr_addr;
    logic                  pend_hit;

    assign accept  = in_valid && in_ready;
    assign in_grid = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
    assign in_addr = {YW'(cell_y), XW'(cell_x)};
    assign cur_x   = cur_reg[XW-1:0];
    assign cur_y   = cur_reg[AW-1:XW];

    // neighbor address of the current cell, rejected past the grid edge
    always_comb
    begin
        nbr_ok   = 1'b0;
        nbr_addr = cur_reg;
        case (dir_reg)
            DIR_W:
            begin
                nbr_ok   = (cur_x != '0);
                nbr_addr = {cur_y, cur_x - XW'(1)};
            end
            DIR_E:
            begin
                nbr_ok   = (32'(cur_x) < GRID_WIDTH - 1);
                nbr_addr = {cur_y, cur_x + XW'(1)};
            end
            DIR_N:
            begin
                nbr_ok   = (cur_y != '0);
                nbr_addr = {cur_y - YW'(1), cur_x};
            end
            DIR_S:
            begin
                nbr_ok   = (32'(cur_y) < GRID_HEIGHT - 1);
                nbr_addr = {cur_y + YW'(1), cur_x};
            end
            default:
            begin
                nbr_ok   = 1'b0;
                nbr_addr = cur_reg;
            end
        endcase
    end

    assign pend_hit = pend_reg && (map_rdata == {seed_tile_reg, seed_attr_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_grid)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        case (func_t'(func))
                            FN_READ, FN_FILL: state_next = ST_RD_WAIT;
                            default:          state_next = ST_RESULT;
                        endcase
                    end
                end
            end
            ST_RD_WAIT:
            begin
                if (func_reg == FN_FILL && map_rdata != {new_tile_reg, new_attr_reg})
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_POP:
            begin
                state_next = (head_reg == tail_reg) ? ST_RESULT : ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                state_next = ST_NBR;
            end
            ST_NBR:
            begin
                if (dir_reg == DIR_END)
                begin
                    state_next = ST_POP;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        func_next      = func_reg;
        seed_addr_next = seed_addr_reg;
        new_tile_next  = new_tile_reg;
        new_attr_next  = new_attr_reg;
        seed_tile_next = seed_tile_reg;
        seed_attr_next = seed_attr_reg;
        skip_next      = skip_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        dir_next       = dir_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        out_tile_next  = out_tile_reg;
        out_attr_next  = out_attr_reg;
        out_count_next = out_count_reg;
        out_skip_next  = out_skip_reg;
        out_valid_next = out_valid_reg && !out_ready;

        map_we    = 1'b0;
        map_waddr = in_addr;
        map_wdata = {tile_value, attr_value};
        map_re    = 1'b0;
        map_raddr = in_addr;
        q_we      = 1'b0;
        q_waddr   = tail_reg[QIW-1:0];
        q_wdata   = pend_addr_reg;
        q_re      = 1'b0;
        q_raddr   = head_reg[QIW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func_t'(func);
                    seed_addr_next = in_addr;
                    new_tile_next  = tile_value;
                    new_attr_next  = attr_value;
                    seed_tile_next = '0;
                    seed_attr_next = '0;
                    skip_next      = 1'b0;
                    head_next      = '0;
                    tail_next      = '0;
                    if (in_grid)
                    begin
                        map_we = (func_t'(func) == FN_WRITE);
                        map_re = (func_t'(func) == FN_READ) || (func_t'(func) == FN_FILL);
                    end
                end
            end
            ST_RD_WAIT:
            begin
                seed_tile_next = map_rdata[CELL_W-1:BYTE_W];
                seed_attr_next = map_rdata[BYTE_W-1:0];
                if (func_reg == FN_FILL)
                begin
                    if (map_rdata == {new_tile_reg, new_attr_reg})
                    begin
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        // paint the seed and make it the first queue entry
                        map_we    = 1'b1;
                        map_waddr = seed_addr_reg;
                        map_wdata = {new_tile_reg, new_attr_reg};
                        q_we      = 1'b1;
                        q_waddr   = '0;
                        q_wdata   = seed_addr_reg;
                        tail_next = QW'(1);
                    end
                end
            end
            ST_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    q_re      = 1'b1;
                    head_next = head_reg + QW'(1);
                end
            end
            ST_POP_WAIT:
            begin
                cur_next  = q_rdata;
                dir_next  = DIR_W;
                pend_next = 1'b0;
            end
            ST_NBR:
            begin
                // probe this neighbor while checking the one read last cycle
                if (dir_reg != DIR_END)
                begin
                    map_re         = nbr_ok;
                    map_raddr      = nbr_addr;
                    pend_next      = nbr_ok;
                    pend_addr_next = nbr_addr;
                    dir_next       = dir_t'(dir_reg + 3'd1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_hit)
                begin
                    map_we    = 1'b1;
                    map_waddr = pend_addr_reg;
                    map_wdata = {new_tile_reg, new_attr_reg};
                    q_we      = 1'b1;
                    tail_next = tail_reg + QW'(1);
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_tile_next  = seed_tile_reg;
                    out_attr_next  = seed_attr_reg;
                    out_count_next = CNT_W'(tail_reg);
                    out_skip_next  = skip_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            dir_reg       <= DIR_W;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            dir_reg       <= dir_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        seed_addr_reg <= seed_addr_next;
        new_tile_reg  <= new_tile_next;
        new_attr_reg  <= new_attr_next;
        seed_tile_reg <= seed_tile_next;
        seed_attr_reg <= seed_attr_next;
        skip_reg      <= skip_next;
        cur_reg       <= cur_next;
        pend_addr_reg <= pend_addr_next;
        out_tile_reg  <= out_tile_next;
        out_attr_reg  <= out_attr_next;
        out_count_reg <= out_count_next;
        out_skip_reg  <= out_skip_next;
    end

    tgff_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_en   (map_re),
        .rd_addr (map_raddr),
        .rd_data (map_rdata)
    );

    tgff_ram #(
        .WIDTH (AW),
        .DEPTH (CELL_COUNT)
    ) u_queue (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (q_wdata),
        .rd_en   (q_re),
        .rd_addr (q_raddr),
        .rd_data (q_rdata)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign read_tile    = out_tile_reg;
    assign read_attr    = out_attr_reg;
    assign filled_count = out_count_reg;
    assign skipped      = out_skip_reg;

`ifndef SYNTH
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> (32'(tail_reg) < CELL_COUNT))
        else $error("queue push beyond grid size");

    a_map_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (map_we && map_re) |-> (map_waddr != map_raddr))
        else $error("map read and write to the same cell in one cycle");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result shown outside the result step");

    a_drain_to_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NBR && dir_reg == DIR_END) |=> (state_reg == ST_POP))
        else $error("neighbor sweep did not return to pop");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for tile_grid_flood_fill: cell writes, reads and flood fills
// depends on tgff_pkg and the tile_grid_flood_fill rtl; keeps its own mirror of the grid
// and predicts each result, including the full breadth-first repaint
module tb;

    import tgff_pkg::*;

    localparam int GRID_W     = GRID_WIDTH_DEF;
    localparam int GRID_H     = GRID_HEIGHT_DEF;
    localparam int CELLS      = GRID_W * GRID_H;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_PRINTS = 30;
    // the case and random fills run inside a walled corner area of AREA x AREA cells
    localparam int AREA       = 6;
    localparam logic [BYTE_W-1:0] WALL_TILE = 8'hEE;
    localparam logic [BYTE_W-1:0] WALL_ATTR = 8'h11;

    typedef struct packed {
        logic [BYTE_W-1:0] tile;
        logic [BYTE_W-1:0] attr;
        logic [CNT_W-1:0]  count;
        logic              skip;
    } grid_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func = '0;
    logic [COORD_W-1:0]  cell_x = '0;
    logic [COORD_W-1:0]  cell_y = '0;
    logic [BYTE_W-1:0]   tile_value = '0;
    logic [BYTE_W-1:0]   attr_value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BYTE_W-1:0]   read_tile;
    logic [BYTE_W-1:0]   read_attr;
    logic [CNT_W-1:0]    filled_count;
    logic                skipped;

    // mirror of the grid contents as the block should hold them
    logic [BYTE_W-1:0] tile_mirror [CELLS];
    logic [BYTE_W-1:0] attr_mirror [CELLS];
    grid_result_t      awaited_results [$];

    bit steady = 1'b0;
    int error_count = 0;
    int results_checked = 0;
    int idle_cycles = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_fills = 0;
    int n_skips = 0;
    int n_unused = 0;
    int cells_painted = 0;

    tile_grid_flood_fill dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .tile_value   (tile_value),
        .attr_value   (attr_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_tile    (read_tile),
        .read_attr    (read_attr),
        .filled_count (filled_count),
        .skipped      (skipped)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 26);
    end

    // breadth-first 4-connected repaint of the mirror, returns the painted count
    function automatic logic [CNT_W-1:0] flood_repaint(int seed, logic [BYTE_W-1:0] nt,
                                                       logic [BYTE_W-1:0] na);
        logic [BYTE_W-1:0] st;
        logic [BYTE_W-1:0] sa;
        bit                queued [CELLS];
        int                frontier [$];
        int                cur;
        int                cx;
        int                cy;
        int                nx;
        int                ny;
        int                nb;
        int                painted;
        st = tile_mirror[seed];
        sa = attr_mirror[seed];
        painted = 0;
        frontier.push_back(seed);
        queued[seed] = 1'b1;
        while (frontier.size() > 0)
        begin
            cur = frontier.pop_front();
            cx = cur % GRID_W;
            cy = cur / GRID_W;
            tile_mirror[cur] = nt;
            attr_mirror[cur] = na;
            painted++;
            for (int d = 0; d < 4; d++)
            begin
                nx = cx;
                ny = cy;
                case (d)
                    0: nx = cx - 1;
                    1: nx = cx + 1;
                    2: ny = cy - 1;
                    default: ny = cy + 1;
                endcase
                if (nx >= 0 && nx < GRID_W && ny >= 0 && ny < GRID_H)
                begin
                    nb = ny * GRID_W + nx;
                    if (!queued[nb] && tile_mirror[nb] == st && attr_mirror[nb] == sa)
                    begin
                        queued[nb] = 1'b1;
                        frontier.push_back(nb);
                    end
                end
            end
        end
        return painted[CNT_W-1:0];
    endfunction

    // applies one command to the mirror and returns the result it must produce
    function automatic grid_result_t apply_grid_cmd(func_t op, logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y,
                                                    logic [BYTE_W-1:0] t,
                                                    logic [BYTE_W-1:0] a);
        grid_result_t r;
        int           idx;
        r = '0;
        // 5-bit coordinates always land inside the 32x32 grid
        idx = int'(y) * GRID_W + int'(x);
        case (op)
            FN_WRITE:
            begin
                tile_mirror[idx] = t;
                attr_mirror[idx] = a;
                n_writes++;
            end
            FN_READ:
            begin
                r.tile = tile_mirror[idx];
                r.attr = attr_mirror[idx];
                n_reads++;
            end
            FN_FILL:
            begin
                r.tile = tile_mirror[idx];
                r.attr = attr_mirror[idx];
                n_fills++;
                if (r.tile == t && r.attr == a)
                begin
                    r.skip = 1'b1;
                    n_skips++;
                end
                else
                begin
                    r.count = flood_repaint(idx, t, a);
                    cells_painted += int'(r.count);
                end
            end
            default:
                n_unused++;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // drives one command and holds it until the transfer happens
    task automatic send_cmd(func_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [BYTE_W-1:0] t, logic [BYTE_W-1:0] a);
        int gap;
        bit took;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 26)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        cell_x     <= x;
        cell_y     <= y;
        tile_value <= t;
        attr_value <= a;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        awaited_results.push_back(apply_grid_cmd(op, x, y, t, a));
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_tile();
        case ($urandom_range(0, 5))
            0, 1: return 8'h00;
            2:    return 8'h01;
            3:    return 8'h02;
            4:    return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // never the wall attribute, so painted cells can not merge into the wall
    function automatic logic [BYTE_W-1:0] pick_attr();
        case ($urandom_range(0, 4))
            0, 1: return 8'h00;
            2:    return 8'h80;
            3:    return 8'h7F;
            default: return BYTE_W'($urandom_range(32'h20, 32'hFF));
        endcase
    endfunction

    // the corner area and its wall get written first; fills seeded in the area never
    // leave it, so no read or fill probe ever sees an unwritten cell
    task automatic test_grid_setup();
        steady = 1'b1;
        for (int yy = 0; yy < AREA; yy++)
            for (int xx = 0; xx < AREA; xx++)
                send_cmd(FN_WRITE, COORD_W'(xx), COORD_W'(yy), 8'h00, 8'h00);
        for (int k = 0; k <= AREA; k++)
            send_cmd(FN_WRITE, COORD_W'(AREA), COORD_W'(k), WALL_TILE, WALL_ATTR);
        for (int k = 0; k < AREA; k++)
            send_cmd(FN_WRITE, COORD_W'(k), COORD_W'(AREA), WALL_TILE, WALL_ATTR);
        steady = 1'b0;
    endtask

    task automatic test_extremes();
        send_cmd(FN_WRITE, 5'd0, 5'd0, 8'hFF, 8'hFF);
        send_cmd(FN_WRITE, 5'd31, 5'd31, 8'hFF, 8'h00);
        send_cmd(FN_WRITE, 5'd31, 5'd0, 8'h00, 8'hFF);
        send_cmd(FN_WRITE, 5'd0, 5'd31, 8'hAA, 8'h55);
        send_cmd(FN_WRITE, 5'd30, 5'd31, 8'h00, 8'h00);
        send_cmd(FN_WRITE, 5'd31, 5'd30, 8'h01, 8'h00);
        send_cmd(FN_READ, 5'd0, 5'd0, 8'h00, 8'h00);
        send_cmd(FN_READ, 5'd31, 5'd31, 8'hFF, 8'hFF);
        send_cmd(FN_READ, 5'd31, 5'd0, 8'h00, 8'h00);
        send_cmd(FN_READ, 5'd0, 5'd31, 8'h00, 8'h00);
        send_cmd(FN_READ, 5'd3, 5'd3, 8'h00, 8'h00);
        // unused code must leave the grid alone and answer zeros
        send_cmd(FN_NONE, 5'd31, 5'd31, 8'hFF, 8'hFF);
        send_cmd(FN_READ, 5'd31, 5'd31, 8'h00, 8'h00);
        // far corner seed with both in-grid neighbors different
        send_cmd(FN_FILL, 5'd31, 5'd31, 8'h12, 8'h34);
        send_cmd(FN_READ, 5'd31, 5'd31, 8'h00, 8'h00);
    endtask

    task automatic test_fill_cases();
        drain_results();
        // isolated corner cell
        send_cmd(FN_FILL, 5'd0, 5'd0, 8'h12, 8'h34);
        send_cmd(FN_FILL, 5'd0, 5'd0, 8'h12, 8'h34);
        // background region, first tile only then attribute only
        send_cmd(FN_FILL, 5'd4, 5'd4, 8'h01, 8'h00);
        send_cmd(FN_FILL, 5'd4, 5'd4, 8'h01, 8'h80);
        send_cmd(FN_READ, 5'd4, 5'd4, 8'h00, 8'h00);
        drain_results();
        // make the corner area uniform, then repaint all of it twice
        send_cmd(FN_WRITE, 5'd0, 5'd0, 8'h01, 8'h80);
        send_cmd(FN_FILL, 5'd5, 5'd5, 8'hFF, 8'hFF);
        send_cmd(FN_FILL, 5'd0, 5'd5, 8'h00, 8'h00);
        send_cmd(FN_READ, 5'd5, 5'd0, 8'h00, 8'h00);
    endtask

    // mostly wall segments and fills so regions stay bounded and varied
    task automatic test_random(int n);
        int                 sent;
        int                 pick;
        int                 len;
        bit                 horiz;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  t;
        logic [BYTE_W-1:0]  a;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            x = COORD_W'($urandom_range(0, AREA - 1));
            y = COORD_W'($urandom_range(0, AREA - 1));
            if (pick < 45)
            begin
                len = $urandom_range(1, 8);
                horiz = $urandom_range(0, 1);
                t = pick_tile();
                a = pick_attr();
                for (int k = 0; k < len && sent < n; k++)
                begin
                    send_cmd(FN_WRITE, x, y, t, a);
                    sent++;
                    // segments wrap inside the area
                    if (horiz)
                        x = (x == COORD_W'(AREA - 1)) ? '0 : x + 1'b1;
                    else
                        y = (y == COORD_W'(AREA - 1)) ? '0 : y + 1'b1;
                end
            end
            else if (pick < 63)
            begin
                send_cmd(FN_READ, x, y, BYTE_W'($urandom), BYTE_W'($urandom));
                sent++;
            end
            else if (pick < 96)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // seed already holds the new values
                    t = tile_mirror[int'(y) * GRID_W + int'(x)];
                    a = attr_mirror[int'(y) * GRID_W + int'(x)];
                end
                else
                begin
                    t = pick_tile();
                    a = pick_attr();
                end
                if ($urandom_range(0, 9) == 0)
                    drain_results();
                send_cmd(FN_FILL, x, y, t, a);
                sent++;
            end
            else
            begin
                send_cmd(FN_NONE, x, y, BYTE_W'($urandom), BYTE_W'($urandom));
                sent++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        grid_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (read_tile !== want.tile)
                    report_mismatch($sformatf("read_tile %0h, expected %0h",
                                              read_tile, want.tile));
                if (read_attr !== want.attr)
                    report_mismatch($sformatf("read_attr %0h, expected %0h",
                                              read_attr, want.attr));
                if (filled_count !== want.count)
                    report_mismatch($sformatf("filled_count %0d, expected %0d",
                                              filled_count, want.count));
                if (skipped !== want.skip)
                    report_mismatch($sformatf("skipped %0b, expected %0b",
                                              skipped, want.skip));
            end
        end
    end

    // ends a hung run: no transfer on either side for too long
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tile_grid_flood_fill test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_grid_setup();
        test_extremes();
        test_fill_cases();
        test_random(46);
        steady = 1'b1;
        test_random(20);
        steady = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d writes, %0d reads, %0d fills (%0d skipped, %0d cells repainted)",
                 n_writes, n_reads, n_fills, n_skips, cells_painted);
        $display("%0d unused-code commands, %0d results checked, %0d mismatches",
                 n_unused, results_checked, error_count);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("tile_grid_flood_fill test passed");
        else
            $display("tile_grid_flood_fill test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tgff_pkg.sv
sv/tgff_ram.sv
sv/tile_grid_flood_fill.sv
dv/tb.sv
